/* src/assert_macros.svh */
// assertion macros shared by the scheduler rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked every clock edge outside reset
`define RRFS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define RRFS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/rrfs_pkg.sv */
// shared constants, types and codes of the round-robin fiber scheduler
package rrfs_pkg;

  localparam int unsigned NUM_FIBERS = 16;
  localparam int unsigned ID_W       = $clog2(NUM_FIBERS);
  localparam int unsigned CNT_W      = $clog2(NUM_FIBERS + 1);
  localparam int unsigned REQ_W      = 3;
  localparam int unsigned RES_W      = 2;
  localparam int unsigned BUDGET_W   = 16;
  localparam logic [BUDGET_W-1:0] BUDGET_RESET = 16'd1000;

  // apb register file
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned PADDR_W    = 3;
  localparam int unsigned REG_IDX_W  = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_DEFAULT_BUDGET = '0;

  // request codes
  localparam logic [REQ_W-1:0] REQ_SPAWN  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_TICK   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_BLOCK  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_FINISH = 3'd3;
  localparam logic [REQ_W-1:0] REQ_WAKE   = 3'd4;

  // result status codes
  localparam logic [RES_W-1:0] RES_DONE    = 2'd0;
  localparam logic [RES_W-1:0] RES_IGNORED = 2'd1;
  localparam logic [RES_W-1:0] RES_BUSY    = 2'd2;

  typedef enum logic [1:0] {
    FS_FREE     = 2'd0,
    FS_RUNNABLE = 2'd1,
    FS_RUNNING  = 2'd2,
    FS_BLOCKED  = 2'd3
  } fiber_state_e;

  // run queue control from the scheduler
  typedef struct packed {
    logic            push;
    logic [ID_W-1:0] push_id;
    logic            pop;
  } q_ctrl_t;

  // run queue state seen by the scheduler
  typedef struct packed {
    logic [CNT_W-1:0] fill;
    logic [ID_W-1:0]  head_id;
  } q_stat_t;

  // one result
  typedef struct packed {
    logic             running_valid;
    logic [ID_W-1:0]  running_id;
    logic             switched;
    logic [RES_W-1:0] status;
    logic [CNT_W-1:0] queue_count;
  } sched_res_t;

endpackage

/* src/rrfs_intf.sv */
// request and result channel interfaces of the scheduler

interface rrfs_req_if;
  logic                        valid;
  logic                        ready;
  logic [rrfs_pkg::REQ_W-1:0]  req_type;
  logic [rrfs_pkg::ID_W-1:0]   fiber_id;

  modport source (output valid, output req_type, output fiber_id, input ready);
  modport sink   (input valid, input req_type, input fiber_id, output ready);
endinterface

interface rrfs_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        running_valid;
  logic [rrfs_pkg::ID_W-1:0]   running_id;
  logic                        switched;
  logic [rrfs_pkg::RES_W-1:0]  status;
  logic [rrfs_pkg::CNT_W-1:0]  queue_count;

  modport source (output valid, output running_valid, output running_id,
                  output switched, output status, output queue_count, input ready);
  modport sink   (input valid, input running_valid, input running_id,
                  input switched, input status, input queue_count, output ready);
endinterface

/* src/rrfs_cfg.sv */
// apb register file holding the dispatch budget
module rrfs_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rrfs_pkg::PADDR_W-1:0]        paddr,
  input  logic [rrfs_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [rrfs_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  output logic [rrfs_pkg::BUDGET_W-1:0]       reload_budget_o
);

  logic [rrfs_pkg::BUDGET_W-1:0]  budget_q, budget_d;
  logic [rrfs_pkg::REG_IDX_W-1:0] reg_idx;
  logic                           wr_en;

  assign reg_idx = paddr[rrfs_pkg::PADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    budget_d = budget_q;
    if (wr_en && (reg_idx == rrfs_pkg::REG_DEFAULT_BUDGET)) begin
      budget_d = pwdata[rrfs_pkg::BUDGET_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      budget_q <= rrfs_pkg::BUDGET_RESET;
    end else begin
      budget_q <= budget_d;
    end
  end

  assign prdata = (reg_idx == rrfs_pkg::REG_DEFAULT_BUDGET) ?
                  rrfs_pkg::APB_DATA_W'(budget_q) : '0;
  assign reload_budget_o = budget_q;

endmodule

/* src/rrfs_queue.sv */
// circular run queue of fiber ids
module rrfs_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rrfs_pkg::q_ctrl_t ctrl_i,
  output rrfs_pkg::q_stat_t stat_o
);

  logic [rrfs_pkg::ID_W-1:0]  store_q [rrfs_pkg::NUM_FIBERS];
  logic [rrfs_pkg::ID_W-1:0]  head_q, head_d;
  logic [rrfs_pkg::ID_W-1:0]  tail_q, tail_d;
  logic [rrfs_pkg::CNT_W-1:0] fill_q, fill_d;

  // pointers wrap naturally at the queue depth
  always_comb begin
    head_d = ctrl_i.pop  ? head_q + rrfs_pkg::ID_W'(1) : head_q;
    tail_d = ctrl_i.push ? tail_q + rrfs_pkg::ID_W'(1) : tail_q;
    fill_d = fill_q + rrfs_pkg::CNT_W'(ctrl_i.push) - rrfs_pkg::CNT_W'(ctrl_i.pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      fill_q <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      store_q[tail_q] <= ctrl_i.push_id;
    end
  end

  assign stat_o.fill    = fill_q;
  assign stat_o.head_id = store_q[head_q];

endmodule

/* src/rrfs_sched.sv */
// fiber status table, running fiber and budget, one event per cycle while fire_i is high
module rrfs_sched (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           fire_i,
  input  logic [rrfs_pkg::REQ_W-1:0]     req_type_i,
  input  logic [rrfs_pkg::ID_W-1:0]      fiber_id_i,
  input  logic [rrfs_pkg::BUDGET_W-1:0]  reload_budget_i,
  input  rrfs_pkg::q_stat_t              q_stat_i,
  output rrfs_pkg::q_ctrl_t              q_ctrl_o,
  output rrfs_pkg::sched_res_t           res_o
);

  rrfs_pkg::fiber_state_e tab_q [rrfs_pkg::NUM_FIBERS];
  rrfs_pkg::fiber_state_e tab_d [rrfs_pkg::NUM_FIBERS];
  logic [rrfs_pkg::ID_W-1:0]     cur_q, cur_d;
  logic                          run_q, run_d;
  logic [rrfs_pkg::BUDGET_W-1:0] budget_q, budget_d;

  rrfs_pkg::fiber_state_e        id_state;
  rrfs_pkg::fiber_state_e        wr_val;
  logic                          wr_en;
  logic [rrfs_pkg::ID_W-1:0]     wr_id;
  logic                          push;
  logic                          push_ok;
  logic [rrfs_pkg::ID_W-1:0]     push_id;
  logic                          stop;
  logic                          pop;
  logic [rrfs_pkg::ID_W-1:0]     disp_id;
  logic [rrfs_pkg::RES_W-1:0]    res_status;
  logic                          q_full;

  assign id_state = tab_q[fiber_id_i];
  assign q_full   = (q_stat_i.fill == rrfs_pkg::CNT_W'(rrfs_pkg::NUM_FIBERS));

  // event decode
  always_comb begin
    res_status = rrfs_pkg::RES_IGNORED;
    wr_en      = 1'b0;
    wr_id      = fiber_id_i;
    wr_val     = rrfs_pkg::FS_RUNNABLE;
    push       = 1'b0;
    push_id    = fiber_id_i;
    stop       = 1'b0;
    budget_d   = budget_q;
    unique case (req_type_i)
      rrfs_pkg::REQ_SPAWN: begin
        if (id_state == rrfs_pkg::FS_FREE) begin
          wr_en      = 1'b1;
          push       = 1'b1;
          res_status = rrfs_pkg::RES_DONE;
        end else begin
          res_status = rrfs_pkg::RES_BUSY;
        end
      end
      rrfs_pkg::REQ_TICK: begin
        if (run_q) begin
          res_status = rrfs_pkg::RES_DONE;
          if (budget_q != '0) begin
            budget_d = budget_q - rrfs_pkg::BUDGET_W'(1);
          end else begin
            // quantum spent: requeue the running fiber at the tail
            wr_en   = 1'b1;
            wr_id   = cur_q;
            push    = 1'b1;
            push_id = cur_q;
            stop    = 1'b1;
          end
        end
      end
      rrfs_pkg::REQ_BLOCK, rrfs_pkg::REQ_FINISH: begin
        if (run_q) begin
          res_status = rrfs_pkg::RES_DONE;
          wr_en      = 1'b1;
          wr_id      = cur_q;
          wr_val     = (req_type_i == rrfs_pkg::REQ_BLOCK) ? rrfs_pkg::FS_BLOCKED
                                                           : rrfs_pkg::FS_FREE;
          stop       = 1'b1;
        end
      end
      rrfs_pkg::REQ_WAKE: begin
        if (id_state == rrfs_pkg::FS_BLOCKED) begin
          wr_en      = 1'b1;
          push       = 1'b1;
          res_status = rrfs_pkg::RES_DONE;
        end
      end
      default: begin
      end
    endcase
  end

  // dispatch when idle after the event and a fiber is waiting
  always_comb begin
    push_ok = fire_i && push && !q_full;
    run_d   = run_q && !(fire_i && stop);
    pop     = fire_i && !run_d && ((q_stat_i.fill != '0) || push_ok);
    // empty queue: the fiber pushed in this cycle is the head
    disp_id = (q_stat_i.fill == '0) ? push_id : q_stat_i.head_id;
    cur_d   = cur_q;
    if (pop) begin
      run_d = 1'b1;
      cur_d = disp_id;
    end
  end

  always_comb begin
    for (int i = 0; i < int'(rrfs_pkg::NUM_FIBERS); i++) begin
      tab_d[i] = tab_q[i];
      if (fire_i && wr_en && (wr_id == rrfs_pkg::ID_W'(i))) begin
        tab_d[i] = wr_val;
      end
      if (pop && (disp_id == rrfs_pkg::ID_W'(i))) begin
        tab_d[i] = rrfs_pkg::FS_RUNNING;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(rrfs_pkg::NUM_FIBERS); i++) begin
        tab_q[i] <= rrfs_pkg::FS_FREE;
      end
      cur_q    <= '0;
      run_q    <= 1'b0;
      budget_q <= '0;
    end else begin
      tab_q <= tab_d;
      cur_q <= cur_d;
      run_q <= run_d;
      if (pop) begin
        budget_q <= reload_budget_i;
      end else if (fire_i) begin
        budget_q <= budget_d;
      end
    end
  end

  assign q_ctrl_o.push    = push_ok;
  assign q_ctrl_o.push_id = push_id;
  assign q_ctrl_o.pop     = pop;

  assign res_o.running_valid = run_d;
  assign res_o.running_id    = run_d ? cur_d : '0;
  assign res_o.switched      = pop;
  assign res_o.status        = res_status;
  assign res_o.queue_count   = q_stat_i.fill + rrfs_pkg::CNT_W'(push_ok)
                               - rrfs_pkg::CNT_W'(pop);

endmodule

/* src/round_robin_fiber_scheduler_core.sv */
// top level of the round-robin fiber scheduler
// Round-robin fiber scheduler for 16 fiber ids with a per-dispatch tick budget.
// Each request (spawn, safepoint tick, block, finish, wake) gives exactly one
// result with the running fiber, a switched flag, a status code and the run
// queue depth. Requests are taken one per cycle, sustained: a request is
// registered on acceptance, the status table, run queue and budget are updated
// when the request advances, in a single combinational pass, and the result is
// registered together with them. The rate is set by that single-pass update
// of the status table and the queue pointers; back pressure on the result
// side stalls both stages together. The budget reload register (reset 1000)
// sits at byte address 0 of the apb port and should only be written while no
// request is in flight. No clearing pass is needed after reset.
`include "assert_macros.svh"

module round_robin_fiber_scheduler_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  rrfs_req_if.sink                         req_i,
  rrfs_rsp_if.source                       rsp_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rrfs_pkg::PADDR_W-1:0]     paddr,
  input  logic [rrfs_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [rrfs_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready
);

  // input stage
  logic                           in_valid_q;
  logic [rrfs_pkg::REQ_W-1:0]     in_req_q;
  logic [rrfs_pkg::ID_W-1:0]      in_id_q;
  // result stage
  logic                           out_valid_q, out_valid_d;
  rrfs_pkg::sched_res_t           out_res_q;

  logic                           advance;
  logic                           in_take;
  logic [rrfs_pkg::BUDGET_W-1:0]  reload_budget;
  rrfs_pkg::q_ctrl_t              q_ctrl;
  rrfs_pkg::q_stat_t              q_stat;
  rrfs_pkg::sched_res_t           res;

  // the registered request moves on when the result slot is free or drains
  assign advance     = in_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !in_valid_q || advance;
  assign in_take     = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      in_valid_q <= req_i.valid;
    end
  end

  // request payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_req_q <= req_i.req_type;
      in_id_q  <= req_i.fiber_id;
    end
  end

  rrfs_cfg u_cfg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .reload_budget_o (reload_budget)
  );

  rrfs_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (q_ctrl),
    .stat_o (q_stat)
  );

  rrfs_sched u_sched (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .fire_i          (advance),
    .req_type_i      (in_req_q),
    .fiber_id_i      (in_id_q),
    .reload_budget_i (reload_budget),
    .q_stat_i        (q_stat),
    .q_ctrl_o        (q_ctrl),
    .res_o           (res)
  );

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= res;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.running_valid = out_res_q.running_valid;
  assign rsp_o.running_id    = out_res_q.running_id;
  assign rsp_o.switched      = out_res_q.switched;
  assign rsp_o.status        = out_res_q.status;
  assign rsp_o.queue_count   = out_res_q.queue_count;

  // an idle scheduler always has an empty run queue
  `RRFS_ASSERT(a_idle_queue_empty, clk_i, rst_ni,
    !(rsp_o.valid && !rsp_o.running_valid) ||
    (rsp_o.queue_count == '0 && rsp_o.running_id == '0),
    "idle result with waiting fibers or nonzero id")

  // a dispatch always leaves a fiber running
  `RRFS_ASSERT(a_switch_runs, clk_i, rst_ni,
    !(rsp_o.valid && rsp_o.switched) || rsp_o.running_valid,
    "switched without a running fiber")

  // the queue never holds more fibers than there are ids
  `RRFS_ASSERT(a_queue_bound, clk_i, rst_ni,
    !rsp_o.valid || (rsp_o.queue_count <= rrfs_pkg::CNT_W'(rrfs_pkg::NUM_FIBERS)),
    "queue count above fiber count")

  // a request that moves on shows up as a result in the next cycle
  `RRFS_ASSERT_NEXT(a_advance_result, clk_i, rst_ni, advance, rsp_o.valid,
    "advanced request produced no result")

endmodule
